// File: sv/kpc_pkg.sv
// Package for the key press classifier: payload structs, action and register codes,
// button state encoding and the control/status structs of one button slice.
// No dependencies.
package kpc_pkg;

  localparam int unsigned MAX_BUTTONS_DEF = 8;
  localparam int unsigned CNT_W           = 4;
  localparam int unsigned CODE_W          = 8;
  localparam int unsigned MASK_W          = 16;
  localparam int unsigned TICK_W          = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;

  localparam logic [TICK_W-1:0] LONG_TICKS_RST = TICK_W'(100);
  localparam logic [TICK_W-1:0] HOLD_TICKS_RST = TICK_W'(20);

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_QUERY_PRSD = 3'd1,
    ACT_QUERY_LONG = 3'd2,
    ACT_QUERY_TOGL = 3'd3,
    ACT_TAKE_KEY   = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUTTON_COUNT = 3'd0,
    CFG_BUTTON_CODES = 3'd1,
    CFG_MASKS_LOW    = 3'd2,
    CFG_MASKS_HIGH   = 3'd3,
    CFG_LONG_TICKS   = 3'd4,
    CFG_HOLD_TICKS   = 3'd5,
    CFG_LOCKED       = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BTN_IDLE  = 2'd0,
    BTN_SHORT = 2'd1,
    BTN_LONG  = 2'd2,
    BTN_HELD  = 2'd3
  } btn_state_e;

  typedef struct packed {
    logic [2:0]        action;
    logic [MASK_W-1:0] key_mask;
    logic [CODE_W-1:0] key_code;
  } kpc_req_t;

  typedef struct packed {
    logic              answer;
    logic [CODE_W-1:0] latched_key;
  } kpc_rsp_t;

  typedef struct packed {
    logic tick;
    logic hit;
    logic to_held;
    logic clr_flag;
  } kpc_btn_ctrl_t;

  typedef struct packed {
    btn_state_e state;
    logic       toggled;
  } kpc_btn_stat_t;

endpackage

// File: sv/key_press_classifier_top.sv
// Top level of the key press classifier: configuration registers, button slices,
// query priority logic and a two-entry output buffer. Depends on kpc_pkg, kpc_button.
//
// Usage:
//   Requests arrive on in_valid_i / in_req_i and are taken when in_stall_o is low.
//   Each request gives exactly one response on out_valid_o / out_rsp_o, taken when
//   out_stall_i is low. A tick request updates all buttons in use at once unless
//   locked; query requests look up buttons by key code, lowest button first.
//   out_valid_o and out_rsp_o come from registers; one request is accepted
//   every cycle while the receiver keeps up. Button state updates and the response
//   are both computed in the acceptance cycle from registered state.
//   When the receiver stalls, the response waits in the output register and one
//   more request may be accepted into the skid register; in_stall_o then rises
//   until the receiver drains a response.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered,
//   are meant only while idle, and never touch a running timer.
//   Reset: all buttons not pressed, timers at 100 ticks, flags and latched key
//   cleared, registers at their defaults, output buffer empty.
module key_press_classifier_top #(
  parameter int unsigned MAX_BUTTONS = kpc_pkg::MAX_BUTTONS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kpc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  kpc_pkg::kpc_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output kpc_pkg::kpc_rsp_t                out_rsp_o
);
  import kpc_pkg::*;

  logic [CNT_W-1:0]      button_count_q;
  logic [CFG_DATA_W-1:0] button_codes_q;
  logic [CFG_DATA_W-1:0] masks_low_q;
  logic [CFG_DATA_W-1:0] masks_high_q;
  logic [TICK_W-1:0]     long_ticks_q;
  logic [TICK_W-1:0]     hold_ticks_q;
  logic                  locked_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_count_q <= '0;
      button_codes_q <= '0;
      masks_low_q    <= '0;
      masks_high_q   <= '0;
      long_ticks_q   <= LONG_TICKS_RST;
      hold_ticks_q   <= HOLD_TICKS_RST;
      locked_q       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BUTTON_COUNT: button_count_q <= cfg_wdata_i[CNT_W-1:0];
        CFG_BUTTON_CODES: button_codes_q <= cfg_wdata_i;
        CFG_MASKS_LOW:    masks_low_q    <= cfg_wdata_i;
        CFG_MASKS_HIGH:   masks_high_q   <= cfg_wdata_i;
        CFG_LONG_TICKS:   long_ticks_q   <= cfg_wdata_i[TICK_W-1:0];
        CFG_HOLD_TICKS:   hold_ticks_q   <= cfg_wdata_i[TICK_W-1:0];
        CFG_LOCKED:       locked_q       <= cfg_wdata_i[0];
        default:          ;
      endcase
    end
  end

  logic             skid_valid_q;
  logic             out_valid_q;
  kpc_rsp_t         out_rsp_q, skid_rsp_q;
  logic             in_fire, out_fire;
  logic [CNT_W-1:0] n_used;
  logic             do_tick;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign out_fire   = out_valid_q & ~out_stall_i;
  assign n_used     = (button_count_q > CNT_W'(MAX_BUTTONS)) ? CNT_W'(MAX_BUTTONS)
                                                             : button_count_q;
  assign do_tick    = in_fire && (in_req_i.action == ACT_TICK) && !locked_q;

  logic [MAX_BUTTONS-1:0] in_use, code_eq, hit, match_any, match_long;
  logic [MAX_BUTTONS-1:0] first_long, first_code, flags;
  logic [MAX_BUTTONS-1:0][CODE_W-1:0] codes;
  kpc_btn_ctrl_t [MAX_BUTTONS-1:0] btn_ctrl;
  kpc_btn_stat_t [MAX_BUTTONS-1:0] btn_stat;

  for (genvar i = 0; i < MAX_BUTTONS; i++) begin : g_btn
    logic [MASK_W-1:0] mask;
    if (i < 4) begin : g_lo
      assign mask = masks_low_q[MASK_W*i +: MASK_W];
    end else begin : g_hi
      assign mask = masks_high_q[MASK_W*(i-4) +: MASK_W];
    end
    assign codes[i]      = button_codes_q[CODE_W*i +: CODE_W];
    assign in_use[i]     = CNT_W'(i) < n_used;
    assign code_eq[i]    = in_use[i] && (codes[i] == in_req_i.key_code);
    assign hit[i]        = |(in_req_i.key_mask & mask);
    assign match_any[i]  = code_eq[i] && (btn_stat[i].state != BTN_IDLE);
    assign match_long[i] = code_eq[i] && (btn_stat[i].state == BTN_LONG);
    assign flags[i]      = btn_stat[i].toggled;

    assign btn_ctrl[i].tick     = do_tick && in_use[i];
    assign btn_ctrl[i].hit      = hit[i];
    assign btn_ctrl[i].to_held  = in_fire && first_long[i] &&
                                  (in_req_i.action == ACT_QUERY_PRSD ||
                                   in_req_i.action == ACT_QUERY_LONG);
    assign btn_ctrl[i].clr_flag = in_fire && first_code[i] &&
                                  (in_req_i.action == ACT_QUERY_TOGL);

    kpc_button u_button (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (btn_ctrl[i]),
      .long_ticks_i (long_ticks_q),
      .hold_ticks_i (hold_ticks_q),
      .stat_o       (btn_stat[i])
    );
  end

  always_comb begin
    logic found_l, found_c;
    found_l    = 1'b0;
    found_c    = 1'b0;
    first_long = '0;
    first_code = '0;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      if (match_long[i] && !found_l) begin
        first_long[i] = 1'b1;
        found_l       = 1'b1;
      end
      if (code_eq[i] && !found_c) begin
        first_code[i] = 1'b1;
        found_c       = 1'b1;
      end
    end
  end

  logic [CODE_W-1:0] pressed_code_q, pressed_code_d;
  kpc_rsp_t          rsp;

  always_comb begin
    pressed_code_d = pressed_code_q;
    rsp            = '0;
    if (in_fire) begin
      unique case (in_req_i.action)
        ACT_TICK: begin
          if (!locked_q) begin
            for (int i = 0; i < MAX_BUTTONS; i++) begin
              if (in_use[i] && hit[i]) pressed_code_d = codes[i];
            end
          end
        end
        ACT_QUERY_PRSD: rsp.answer = |match_any;
        ACT_QUERY_LONG: rsp.answer = |match_long;
        ACT_QUERY_TOGL: rsp.answer = |(first_code & flags);
        ACT_TAKE_KEY: begin
          rsp.latched_key = pressed_code_q;
          pressed_code_d  = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_code_q <= '0;
    end else begin
      pressed_code_q <= pressed_code_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) skid_valid_q <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid_q || out_fire) out_valid_q  <= 1'b1;
        else                          skid_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_rsp_q <= skid_rsp_q;
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) out_rsp_q  <= rsp;
      else                          skid_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry without output entry");

  a_one_to_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_long))
    else $error("more than one button moved to held");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.action == ACT_TAKE_KEY) |=> (pressed_code_q == '0))
    else $error("latched key not cleared after take");

  a_locked_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_req_i.action == ACT_TICK && locked_q) |=> $stable(btn_stat))
    else $error("locked tick changed button state");

endmodule

// File: sv/kpc_button.sv
// One button slice: press state, repeat timer and toggled flag.
// Depends on kpc_pkg for the control/status structs and state encoding.
module kpc_button (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kpc_pkg::kpc_btn_ctrl_t       ctrl_i,
  input  logic [kpc_pkg::TICK_W-1:0]   long_ticks_i,
  input  logic [kpc_pkg::TICK_W-1:0]   hold_ticks_i,
  output kpc_pkg::kpc_btn_stat_t       stat_o
);
  import kpc_pkg::*;

  btn_state_e        state_q, state_d;
  logic [TICK_W-1:0] timer_q, timer_d;
  logic              flag_q, flag_d;
  logic [TICK_W-1:0] timer_dec;

  assign timer_dec = timer_q - TICK_W'(1);

  always_comb begin
    state_d = state_q;
    timer_d = timer_q;
    flag_d  = flag_q;
    if (ctrl_i.tick) begin
      if (ctrl_i.hit) begin
        if (timer_dec == '0) begin
          state_d = BTN_LONG;
          timer_d = hold_ticks_i;
        end else begin
          timer_d = timer_dec;
          if (state_q == BTN_IDLE) state_d = BTN_SHORT;
        end
      end else begin
        state_d = BTN_IDLE;
        timer_d = long_ticks_i;
      end
      if (state_d != state_q && state_d != BTN_LONG) flag_d = 1'b1;
    end else begin
      if (ctrl_i.to_held) state_d = BTN_HELD;
      if (ctrl_i.clr_flag) flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BTN_IDLE;
      timer_q <= LONG_TICKS_RST;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      timer_q <= timer_d;
      flag_q  <= flag_d;
    end
  end

  assign stat_o.state   = state_q;
  assign stat_o.toggled = flag_q;

endmodule
